>>> rtl/bba_pkg.sv
// Shared types and codes for the buddy block allocator.
package bba_pkg;

   localparam int LEVELS_DEF     = 10;
   localparam int OWNER_BITS_DEF = 8;

   typedef enum logic [1:0] {
      ST_FREE  = 2'd0,
      ST_SPLIT = 2'd1,
      ST_ALLOC = 2'd2,
      ST_NONE  = 2'd3
   } node_status_type;

   typedef enum logic {
      OP_ALLOC   = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef struct packed {
      logic        operation;
      logic [10:0] request_size;
      logic [7:0]  owner;
   } req_type;

   typedef struct packed {
      logic       success;
      logic [9:0] block_offset;
   } rsp_type;

endpackage

>>> rtl/buddy_block_allocator_core.sv
// Buddy block allocator top level: tree walker FSM over the node RAM.
//
// Buddy allocator over 2^LEVELS units. The tree lives in a synchronous RAM
// with one write port and one read port, one word per node, and every
// request but an allocate of size zero or above 2^LEVELS walks it one node
// at a time: a node read goes through S_READ (address), then S_EVAL
// (evaluate), a step back up is an S_UP state, and a split level is one fit
// check plus three RAM writes, with one write for a grant and one per merge.
// One request is in flight at a time; the result sits in an output
// register, so a new request is taken while it waits. After reset the block
// writes the root entry in S_INIT before req_ready rises.
module buddy_block_allocator_core #(
   parameter int LEVELS     = bba_pkg::LEVELS_DEF,
   parameter int OWNER_BITS = bba_pkg::OWNER_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bba_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bba_pkg::rsp_type rsp_data
);
   import bba_pkg::*;

   localparam int AW  = LEVELS + 1;
   localparam int SW  = LEVELS + 1;
   localparam int DPW = $clog2(LEVELS + 1);
   localparam int MW  = 2 + OWNER_BITS;

   typedef enum logic [11:0] {
      S_INIT    = 12'b000000000001,
      S_IDLE    = 12'b000000000010,
      S_READ    = 12'b000000000100,
      S_EVAL    = 12'b000000001000,
      S_FIT     = 12'b000000010000,
      S_SPLIT_A = 12'b000000100000,
      S_SPLIT_B = 12'b000001000000,
      S_SPLIT_C = 12'b000010000000,
      S_GRANT   = 12'b000100000000,
      S_UP      = 12'b001000000000,
      S_MERGE   = 12'b010000000000,
      S_DONE    = 12'b100000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic [SW-1:0]    size_ff, size_in;
   logic [LEVELS-1:0] base_ff, base_in;
   logic [DPW-1:0]   depth_ff, depth_in;
   logic [LEVELS:0]  lf_ff, lf_in;
   logic             fin_ff, fin_in;
   logic             freed_ff, freed_in;
   logic             op_ff, op_in;
   logic [10:0]      rq_ff, rq_in;
   logic [OWNER_BITS-1:0] who_ff, who_in;
   logic             ok_ff, ok_in;
   logic [9:0]       off_ff, off_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [MW-1:0]    wr_data;
   logic [MW-1:0]    rd_data;
   node_status_type  rd_status;
   logic [OWNER_BITS-1:0] rd_owner;

   logic [AW-1:0]    left_idx;
   logic [SW-1:0]    region;
   logic [31:0]      req_ext, rq_ext, size_ext, half_ext, own_ext, base_ext;
   logic             is_leaf;

   bba_node_ram #(.AW(AW), .DW(MW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign rd_status = node_status_type'(rd_data[MW-1 -: 2]);
   assign rd_owner  = rd_data[OWNER_BITS-1:0];
   assign left_idx  = {idx_ff[AW-2:0], 1'b0};
   assign region    = SW'(1) << LEVELS;
   assign req_ext   = 32'(req_data.request_size);
   assign rq_ext    = 32'(rq_ff);
   assign size_ext  = 32'(size_ff);
   assign half_ext  = 32'(size_ff >> 1);
   assign own_ext   = 32'(req_data.owner);
   assign base_ext  = 32'(base_ff);
   assign is_leaf   = (depth_ff == DPW'(LEVELS));

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // RAM writes; children that leave the tree are never read again, so
   // merges only rewrite the parent.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = {ST_FREE, {OWNER_BITS{1'b0}}};
      case (state_ff)
         S_INIT: begin
            wr_en   = 1'b1;
            wr_addr = AW'(1);
         end
         S_EVAL: begin
            wr_en = (op_ff == OP_RELEASE) && (rd_status == ST_ALLOC)
                    && (rd_owner == who_ff);
         end
         S_SPLIT_A: begin
            wr_en   = 1'b1;
            wr_data = {ST_SPLIT, {OWNER_BITS{1'b0}}};
         end
         S_SPLIT_B: begin
            wr_en   = 1'b1;
            wr_addr = left_idx;
         end
         S_SPLIT_C: begin
            wr_en   = 1'b1;
            wr_addr = left_idx | AW'(1);
         end
         S_GRANT: begin
            wr_en   = 1'b1;
            wr_data = {ST_ALLOC, who_ff};
         end
         S_MERGE: begin
            wr_en = 1'b1;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      size_in      = size_ff;
      base_in      = base_ff;
      depth_in     = depth_ff;
      lf_in        = lf_ff;
      fin_in       = fin_ff;
      freed_in     = freed_ff;
      op_in        = op_ff;
      rq_in        = rq_ff;
      who_in       = who_ff;
      ok_in        = ok_ff;
      off_in       = off_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_INIT: begin
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.operation;
               rq_in    = req_data.request_size;
               who_in   = own_ext[OWNER_BITS-1:0];
               idx_in   = AW'(1);
               size_in  = region;
               base_in  = '0;
               depth_in = '0;
               freed_in = 1'b0;
               ok_in    = 1'b0;
               off_in   = '0;
               if (req_data.operation == OP_ALLOC &&
                   (req_ext == 32'd0 || req_ext > 32'(region))) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (rd_status == ST_SPLIT) begin
               idx_in   = left_idx;
               size_in  = size_ff >> 1;
               depth_in = depth_ff + DPW'(1);
               state_in = S_READ;
            end else if (op_ff == OP_ALLOC) begin
               state_in = (rd_status == ST_FREE && rq_ext <= size_ext) ? S_FIT : S_UP;
            end else begin
               if (rd_status == ST_ALLOC && rd_owner == who_ff) begin
                  freed_in = 1'b1;
                  fin_in   = 1'b1;
               end else begin
                  fin_in = (rd_status == ST_FREE);
               end
               state_in = S_UP;
            end
         end
         S_FIT: begin
            state_in = (rq_ext <= half_ext && !is_leaf) ? S_SPLIT_A : S_GRANT;
         end
         S_SPLIT_A: begin
            state_in = S_SPLIT_B;
         end
         S_SPLIT_B: begin
            state_in = S_SPLIT_C;
         end
         S_SPLIT_C: begin
            idx_in   = left_idx;
            size_in  = size_ff >> 1;
            depth_in = depth_ff + DPW'(1);
            state_in = S_FIT;
         end
         S_GRANT: begin
            ok_in    = 1'b1;
            off_in   = base_ext[9:0];
            state_in = S_DONE;
         end
         S_UP: begin
            if (idx_ff == AW'(1)) begin
               ok_in    = (op_ff == OP_RELEASE) ? freed_ff : 1'b0;
               state_in = S_DONE;
            end else if (!idx_ff[0]) begin
               // left child finished: move to its buddy
               if (op_ff == OP_ALLOC) begin
                  base_in = base_ff + size_ff[LEVELS-1:0];
               end
               lf_in[depth_ff] = fin_ff;
               idx_in   = idx_ff + AW'(1);
               state_in = S_READ;
            end else begin
               idx_in   = idx_ff >> 1;
               depth_in = depth_ff - DPW'(1);
               if (op_ff == OP_ALLOC) begin
                  base_in = base_ff - size_ff[LEVELS-1:0];
                  size_in = size_ff << 1;
               end else if (lf_ff[depth_ff] && fin_ff) begin
                  state_in = S_MERGE;
               end else begin
                  fin_in = 1'b0;
               end
            end
         end
         S_MERGE: begin
            fin_in   = 1'b1;
            state_in = S_UP;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.success      = ok_ff;
               rsp_data_in.block_offset = off_ff;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      size_ff     <= size_in;
      base_ff     <= base_in;
      depth_ff    <= depth_in;
      lf_ff       <= lf_in;
      fin_ff      <= fin_in;
      freed_ff    <= freed_in;
      op_ff       <= op_in;
      rq_ff       <= rq_in;
      who_ff      <= who_in;
      ok_ff       <= ok_in;
      off_ff      <= off_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> rtl/bba_node_ram.sv
// Node table: one synchronous RAM word per tree node, status plus owner.
module bba_node_ram #(
   parameter int AW = 11,
   parameter int DW = 10
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the buddy block allocator core.
module tb_top;
   import bba_pkg::*;

   localparam int LEVELS    = LEVELS_DEF;
   localparam int NODE_CNT  = 1 << (LEVELS + 1);
   localparam int REGION    = 1 << LEVELS;
   localparam int WALK_MAX  = 3 * NODE_CNT + 64;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   buddy_block_allocator_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // shadow copy of the node tree
   node_status_type tree_st [NODE_CNT];
   logic [7:0]      tree_own[NODE_CNT];

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      req_total;
   int      req_accepted;
   int      rsp_seen;
   int      send_gap;
   int      recv_gap;
   int      hold_left;
   bit      held;
   bit      failed;

   function automatic bit grab_block(int idx, int sz, int base, int need,
                                     logic [7:0] who, output int where);
      int i;
      int s;
      where = 0;
      if (idx >= NODE_CNT || tree_st[idx] == ST_NONE) return 1'b0;
      if (tree_st[idx] == ST_SPLIT) begin
         if (grab_block(2 * idx, sz / 2, base, need, who, where)) return 1'b1;
         return grab_block(2 * idx + 1, sz / 2, base + sz / 2, need, who, where);
      end
      if (tree_st[idx] != ST_FREE || sz < need) return 1'b0;
      i = idx;
      s = sz;
      while (need <= s / 2 && 2 * i + 1 < NODE_CNT) begin
         tree_st[i]         = ST_SPLIT;
         tree_st[2 * i]     = ST_FREE;
         tree_st[2 * i + 1] = ST_FREE;
         tree_own[2 * i]     = '0;
         tree_own[2 * i + 1] = '0;
         i = 2 * i;
         s = s / 2;
      end
      tree_st[i]  = ST_ALLOC;
      tree_own[i] = who;
      where = base;
      return 1'b1;
   endfunction

   function automatic bit free_owner(int idx, logic [7:0] who);
      bit got;
      if (idx >= NODE_CNT) return 1'b0;
      if (tree_st[idx] == ST_ALLOC) begin
         if (tree_own[idx] != who) return 1'b0;
         tree_st[idx]  = ST_FREE;
         tree_own[idx] = '0;
         return 1'b1;
      end
      if (tree_st[idx] != ST_SPLIT || 2 * idx + 1 >= NODE_CNT) return 1'b0;
      got = free_owner(2 * idx, who);
      got = free_owner(2 * idx + 1, who) || got;
      if (tree_st[2 * idx] == ST_FREE && tree_st[2 * idx + 1] == ST_FREE) begin
         tree_st[2 * idx]     = ST_NONE;
         tree_st[2 * idx + 1] = ST_NONE;
         tree_st[idx]         = ST_FREE;
         tree_own[idx]        = '0;
      end
      return got;
   endfunction

   function automatic rsp_type apply_request(req_type r);
      rsp_type res;
      int      where;
      bit      ok;
      where = 0;
      if (r.operation == OP_ALLOC) begin
         if (r.request_size == 0 || r.request_size > REGION) ok = 1'b0;
         else ok = grab_block(1, REGION, 0, r.request_size, r.owner, where);
         if (!ok) where = 0;
      end else begin
         ok = free_owner(1, r.owner);
         where = 0;
      end
      res.success      = ok;
      res.block_offset = where[9:0];
      return res;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic add_req(op_type op, int size, int who);
      req_type r;
      r.operation    = op;
      r.request_size = size[10:0];
      r.owner        = who[7:0];
      pending_reqs.push_back(r);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         send_gap  <= 0;
      end else if (!req_valid || req_ready) begin
         if (send_gap > 0 || pending_reqs.size() == 0) begin
            req_valid <= 1'b0;
            if (send_gap > 0) send_gap <= send_gap - 1;
         end else begin
            req_valid <= 1'b1;
            req_data  <= pending_reqs.pop_front();
            send_gap  <= pick_gap();
         end
      end
   end

   // receiver back-pressure, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap  <= 0;
         hold_left <= 0;
         held      <= 1'b0;
      end else if (!held && req_accepted == 60) begin
         held      <= 1'b1;
         hold_left <= 3000;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap  <= recv_gap - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_valid && rsp_ready) recv_gap <= pick_gap();
      end
   end

   // monitor: predict on accept, check on result
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_rsps.push_back(apply_request(req_data));
            req_accepted <= req_accepted + 1;
         end
         if (rsp_valid && rsp_ready) begin
            rsp_seen <= rsp_seen + 1;
            if (expected_rsps.size() == 0) begin
               $error("unexpected response: success=%0d offset=%0d",
                      rsp_data.success, rsp_data.block_offset);
               failed = 1'b1;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.success !== want.success) begin
                  $error("success: expected %0d, got %0d", want.success, rsp_data.success);
                  failed = 1'b1;
               end
               if (rsp_data.block_offset !== want.block_offset) begin
                  $error("block_offset: expected %0d, got %0d",
                         want.block_offset, rsp_data.block_offset);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   initial begin
      int owners[4];
      int who;
      int sz;
      failed       = 1'b0;
      req_accepted = 0;
      rsp_seen     = 0;
      for (int i = 0; i < NODE_CNT; i++) begin
         tree_st[i]  = ST_NONE;
         tree_own[i] = '0;
      end
      tree_st[1] = ST_FREE;

      // directed: bad sizes, root grant, foreign release, merges, no fit
      add_req(OP_ALLOC, 0, 1);
      add_req(OP_ALLOC, 1025, 1);
      add_req(OP_ALLOC, 2047, 255);
      add_req(OP_RELEASE, 2047, 9);
      add_req(OP_ALLOC, 1024, 255);
      add_req(OP_ALLOC, 1, 3);
      add_req(OP_RELEASE, 0, 3);
      add_req(OP_RELEASE, 0, 255);
      add_req(OP_ALLOC, 1, 0);
      add_req(OP_ALLOC, 1, 0);
      add_req(OP_ALLOC, 3, 170);
      add_req(OP_ALLOC, 512, 85);
      add_req(OP_ALLOC, 513, 85);
      add_req(OP_ALLOC, 100, 170);
      add_req(OP_RELEASE, 1, 0);
      add_req(OP_ALLOC, 2, 7);
      add_req(OP_RELEASE, 0, 170);
      add_req(OP_RELEASE, 0, 85);
      add_req(OP_RELEASE, 0, 7);
      add_req(OP_RELEASE, 0, 7);
      add_req(OP_ALLOC, 1024, 1);
      add_req(OP_RELEASE, 0, 1);

      // random: mostly allocs over a small owner pool, interleaved releases
      for (int i = 0; i < 4; i++) owners[i] = $urandom_range(0, 255);
      for (int i = 0; i < 270; i++) begin
         who = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                           : owners[$urandom_range(0, 3)];
         case ($urandom_range(0, 19))
            0:          add_req(OP_ALLOC, $urandom_range(0, 2047), who);
            1:          add_req(OP_RELEASE, $urandom_range(0, 2047), who);
            2, 3, 4, 5: add_req(OP_RELEASE, 0, who);
            6, 7:       add_req(OP_ALLOC, $urandom_range(65, 1024), who);
            default: begin
               sz = $urandom_range(1, 64);
               add_req(OP_ALLOC, sz, who);
            end
         endcase
      end
      req_total = pending_reqs.size();

      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (req_accepted < req_total || expected_rsps.size() != 0) @(posedge clock);
      repeat (WALK_MAX) @(posedge clock);
      if (!failed) $display("PASS buddy_block_allocator_core");
      else $display("FAIL buddy_block_allocator_core");
      $finish;
   end

   initial begin
      #200_000_000;
      $display("FAIL buddy_block_allocator_core");
      $finish;
   end

endmodule

>>> files.f
rtl/bba_pkg.sv
rtl/bba_node_ram.sv
rtl/buddy_block_allocator_core.sv
sim/tb_top.sv
